/* rtl/core/ile_pkg.sv */
// ----------------------------------------------------------------------------
// ile_pkg: shared types and constants for the indexed list engine
// Operation and status codes, field widths, cell control bundle.
// ----------------------------------------------------------------------------
package ile_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int OP_W     = 2;
  localparam int POS_W    = 5;
  localparam int WORD_W   = 32;
  localparam int FOUND_W  = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 2'd0,
    OP_LOCATE = 2'd1,
    OP_INSERT = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // control bundle broadcast to every cell of the chain
  typedef struct packed {
    logic shift_up;  // insert: open a slot at the position
    logic shift_dn;  // delete: close the slot at the position
    logic cmp;       // capture match flag against the search word
  } cell_ctrl_t;

endpackage

/* rtl/core/indexed_list_engine.sv */
// ----------------------------------------------------------------------------
// indexed_list_engine: ordered list of signed words with a count
// Read, locate, insert-at and delete-at on a chain of word cells.
// ----------------------------------------------------------------------------
//
//  channel | ports                                              | dir
//  --------+----------------------------------------------------+-----
//  in      | in_valid in_stall in_operation in_position in_value | in
//  out     | out_valid out_stall out_data_out out_found_index    | out
//          | out_status out_item_count                          |
//
//  Steps: three per beat (accept, cell update/compare, match encode).
//  The result register loads at the end of the final step, once it is free,
//  and the next beat is taken only after that load, so a new beat is not
//  taken before the last one is through. The chain of cells shifts the whole list
//  in the execute step; the lowest-match encoder works in the final step.
//  Reset: rst_n synchronous, clears the count, the FSM and out_valid.
//  Stalls: the result register holds a finished beat under out_stall while
//  the next beat is taken; the engine waits in its last step if the result
//  register is still full under out_stall.
//
module indexed_list_engine #(
  parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [ile_pkg::OP_W-1:0]             in_operation,
  input  logic [ile_pkg::POS_W-1:0]            in_position,
  input  logic signed [ile_pkg::WORD_W-1:0]    in_value,

  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [ile_pkg::WORD_W-1:0]    out_data_out,
  output logic [ile_pkg::FOUND_W-1:0]          out_found_index,
  output logic [ile_pkg::STATUS_W-1:0]         out_status,
  output logic [ile_pkg::COUNT_W-1:0]          out_item_count
);

  // count must hold CAPACITY itself; positions and count compare at PW bits
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int PW   = (CW > ile_pkg::POS_W) ? CW : ile_pkg::POS_W;
  localparam int IW   = $clog2(CAPACITY);
  // a 5-bit position never reaches past slot 31
  localparam int RD_N = (CAPACITY < 32) ? CAPACITY : 32;
  localparam logic [CW-1:0] CAP_V = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // beat captured at acceptance
  ile_pkg::op_t                       op_r;
  logic [ile_pkg::POS_W-1:0]          pos_r;
  logic signed [ile_pkg::WORD_W-1:0]  val_r;

  // list count (control state)
  logic [CW-1:0] cnt_r, cnt_nxt;

  // partial result formed in the execute step
  ile_pkg::status_t                   stat_r, stat_nxt;
  logic signed [ile_pkg::WORD_W-1:0]  data_r, data_nxt;

  // result register
  logic                               out_valid_r, out_valid_nxt;
  logic signed [ile_pkg::WORD_W-1:0]  out_data_r;
  logic [ile_pkg::FOUND_W-1:0]        out_found_r;
  ile_pkg::status_t                   out_stat_r;
  logic [ile_pkg::COUNT_W-1:0]        out_cnt_r;

  logic in_take, out_load;

  logic [PW-1:0] pos_x, cnt_x;
  logic          pos_in_list, pos_le_cnt, list_full;

  ile_pkg::cell_ctrl_t ctrl;

  logic signed [ile_pkg::WORD_W-1:0] words [CAPACITY];
  logic [CAPACITY-1:0]               match_flags;
  logic signed [ile_pkg::WORD_W-1:0] rd_word;

  logic          loc_hit;
  logic [IW-1:0] loc_idx;
  logic [IW+ile_pkg::FOUND_W-1:0] loc_idx_ext;
  logic [CW+ile_pkg::COUNT_W-1:0] cnt_ext;

  ile_pkg::status_t fin_stat;
  logic [ile_pkg::FOUND_W-1:0] fin_found;

  assign in_take  = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  assign pos_x       = PW'(pos_r);
  assign cnt_x       = PW'(cnt_r);
  assign pos_in_list = (pos_x < cnt_x);
  assign pos_le_cnt  = (pos_x <= cnt_x);
  assign list_full   = (cnt_r == CAP_V);

  // cells move only in the execute step, and only for a legal edit
  always_comb begin
    ctrl.shift_up = (state_r == S_EXEC) && (op_r == ile_pkg::OP_INSERT)
                    && pos_le_cnt && !list_full;
    ctrl.shift_dn = (state_r == S_EXEC) && (op_r == ile_pkg::OP_DELETE) && pos_in_list;
    ctrl.cmp      = (state_r == S_EXEC);
  end

  // the chain: inner slots see both neighbors; slot 0 sees the new value on its left, the top slot itself on its right
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [ile_pkg::WORD_W-1:0] lw, rw;
    if (g == 0) begin : g_lo
      assign lw = val_r;
    end else begin : g_lm
      assign lw = words[g-1];
    end
    if (g == CAPACITY - 1) begin : g_hi
      assign rw = words[g];
    end else begin : g_hm
      assign rw = words[g+1];
    end
    ile_cell #(
      .IDX (g),
      .PW  (PW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .pos        (pos_x),
      .cnt        (cnt_x),
      .value      (val_r),
      .left_word  (lw),
      .right_word (rw),
      .word       (words[g]),
      .match      (match_flags[g])
    );
  end

  // word at the position, before any shift (read and delete)
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (pos_x == PW'(i)) begin
        rd_word = rd_word | words[i];
      end
    end
  end

  ile_first #(
    .N (CAPACITY)
  ) u_first (
    .flags (match_flags),
    .hit   (loc_hit),
    .index (loc_idx)
  );

  assign loc_idx_ext = {{ile_pkg::FOUND_W{1'b0}}, loc_idx};
  assign cnt_ext     = {{ile_pkg::COUNT_W{1'b0}}, cnt_r};

  // execute step: status, read data and count update
  always_comb begin
    stat_nxt = stat_r;
    data_nxt = data_r;
    cnt_nxt  = cnt_r;
    if (state_r == S_EXEC) begin
      stat_nxt = ile_pkg::ST_OK;
      data_nxt = '0;
      case (op_r)
        ile_pkg::OP_READ: begin
          if (pos_in_list) begin
            data_nxt = rd_word;
          end else begin
            stat_nxt = ile_pkg::ST_RANGE;
          end
        end
        ile_pkg::OP_LOCATE: begin
          stat_nxt = ile_pkg::ST_MISSING;  // settled after encode
        end
        ile_pkg::OP_INSERT: begin
          if (!pos_le_cnt) begin
            stat_nxt = ile_pkg::ST_RANGE;
          end else if (list_full) begin
            stat_nxt = ile_pkg::ST_FULL;
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
        ile_pkg::OP_DELETE: begin
          if (pos_in_list) begin
            data_nxt = rd_word;
            cnt_nxt  = cnt_r - CW'(1);
          end else begin
            stat_nxt = ile_pkg::ST_RANGE;
          end
        end
        default: begin
          stat_nxt = ile_pkg::ST_RANGE;
        end
      endcase
    end
  end

  // final step: locate outcome from the encoder
  always_comb begin
    fin_stat  = stat_r;
    fin_found = '0;
    if (op_r == ile_pkg::OP_LOCATE) begin
      if (loc_hit) begin
        fin_stat  = ile_pkg::ST_OK;
        fin_found = loc_idx_ext[ile_pkg::FOUND_W-1:0];
      end else begin
        fin_stat  = ile_pkg::ST_MISSING;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stat_r <= stat_nxt;
    data_r <= data_nxt;
    if (in_take) begin
      op_r  <= ile_pkg::op_t'(in_operation);
      pos_r <= in_position;
      val_r <= in_value;
    end
    if (out_load) begin
      out_data_r  <= data_r;
      out_found_r <= fin_found;
      out_stat_r  <= fin_stat;
      out_cnt_r   <= cnt_ext[ile_pkg::COUNT_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data_out    = out_data_r;
  assign out_found_index = out_found_r;
  assign out_status      = out_stat_r;
  assign out_item_count  = out_cnt_r;

endmodule

/* rtl/core/ile_cell.sv */
// ----------------------------------------------------------------------------
// ile_cell: one storage slot of the list chain
// Holds one word, takes it from a neighbor or the new value on insert/delete, flags a match.
// ----------------------------------------------------------------------------
module ile_cell #(
  parameter int IDX = 0,
  parameter int PW  = 5
) (
  input  logic                                clk,
  input  ile_pkg::cell_ctrl_t                 ctrl,
  input  logic [PW-1:0]                       pos,
  input  logic [PW-1:0]                       cnt,
  input  logic signed [ile_pkg::WORD_W-1:0]   value,
  input  logic signed [ile_pkg::WORD_W-1:0]   left_word,
  input  logic signed [ile_pkg::WORD_W-1:0]   right_word,
  output logic signed [ile_pkg::WORD_W-1:0]   word,
  output logic                                match
);

  localparam logic [PW-1:0] IDX_V = PW'(IDX);

  logic signed [ile_pkg::WORD_W-1:0] word_r, word_nxt;
  logic                              match_r, match_nxt;

  always_comb begin
    word_nxt = word_r;
    if (ctrl.shift_up) begin
      if (IDX_V > pos) begin
        word_nxt = left_word;
      end else if (IDX_V == pos) begin
        word_nxt = value;
      end
    end else if (ctrl.shift_dn && (IDX_V >= pos)) begin
      word_nxt = right_word;
    end
  end

  // only slots below the count take part in a search
  assign match_nxt = ctrl.cmp ? ((word_r == value) && (IDX_V < cnt)) : match_r;

  always_ff @(posedge clk) begin
    word_r  <= word_nxt;
    match_r <= match_nxt;
  end

  assign word  = word_r;
  assign match = match_r;

endmodule

/* rtl/core/ile_first.sv */
// ----------------------------------------------------------------------------
// ile_first: lowest-index match finder
// Isolates the lowest set flag and encodes its index.
// ----------------------------------------------------------------------------
module ile_first #(
  parameter int N = ile_pkg::CAPACITY_DEF
) (
  input  logic [N-1:0]                   flags,
  output logic                           hit,
  output logic [$clog2(N)-1:0]           index
);

  localparam int IW = $clog2(N);

  logic [N-1:0] lowest;

  // two's complement trick keeps only the lowest set bit
  assign lowest = flags & (~flags + N'(1));
  assign hit    = |flags;

  always_comb begin
    index = '0;
    for (int i = 0; i < N; i++) begin
      if (lowest[i]) begin
        index = index | IW'(i);
      end
    end
  end

endmodule
